// ===== hdl/sbhd_pkg.sv =====
`timescale 1ns / 1ps

package sbhd_pkg;

   // default widths of the block counters
   localparam int BIT_COUNT_WIDTH_DEF    = 20;
   localparam int SAMPLE_COUNT_WIDTH_DEF = 16;

   // fixed field widths
   localparam int BRC_W       = 3;
   localparam int SCOUNT_W    = 16;
   localparam int CODE_W      = 5;
   localparam int MAG_W       = 4;
   localparam int NODE_W      = 4;
   localparam int INDEX_W     = 16;
   localparam int BITS_USED_W = 20;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 16;

   // register indexes of the configuration port
   localparam logic [CSR_INDEX_W-1:0] CSR_BIT_RATE_CODE = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLE_COUNT  = 4'd1;

   localparam logic [BRC_W-1:0]  BRC_MAX   = 3'd4;
   localparam logic [NODE_W-1:0] ROOT_NODE = 4'd0;
   localparam logic [NODE_W-1:0] NODE_WRAP = 4'd15;

   localparam int TREES = 5;
   localparam int NODES = 15;

   // entry: bit 7 set marks a leaf with the magnitude in bits 3:0,
   // otherwise bits 3:0 give the next node
   localparam logic [7:0] CODE_TREE [0:TREES-1][0:NODES-1][0:1] = '{
      '{ '{8'h80, 8'h01}, '{8'h81, 8'h02}, '{8'h82, 8'h83},
         '{8'h00, 8'h00}, '{8'h00, 8'h00}, '{8'h00, 8'h00}, '{8'h00, 8'h00},
         '{8'h00, 8'h00}, '{8'h00, 8'h00}, '{8'h00, 8'h00}, '{8'h00, 8'h00},
         '{8'h00, 8'h00}, '{8'h00, 8'h00}, '{8'h00, 8'h00}, '{8'h00, 8'h00} },
      '{ '{8'h80, 8'h01}, '{8'h81, 8'h02}, '{8'h82, 8'h03}, '{8'h83, 8'h84},
         '{8'h00, 8'h00}, '{8'h00, 8'h00}, '{8'h00, 8'h00}, '{8'h00, 8'h00},
         '{8'h00, 8'h00}, '{8'h00, 8'h00}, '{8'h00, 8'h00}, '{8'h00, 8'h00},
         '{8'h00, 8'h00}, '{8'h00, 8'h00}, '{8'h00, 8'h00} },
      '{ '{8'h80, 8'h01}, '{8'h81, 8'h02}, '{8'h82, 8'h03}, '{8'h83, 8'h04},
         '{8'h84, 8'h05}, '{8'h85, 8'h86},
         '{8'h00, 8'h00}, '{8'h00, 8'h00}, '{8'h00, 8'h00}, '{8'h00, 8'h00},
         '{8'h00, 8'h00}, '{8'h00, 8'h00}, '{8'h00, 8'h00}, '{8'h00, 8'h00},
         '{8'h00, 8'h00} },
      '{ '{8'h01, 8'h02}, '{8'h80, 8'h81}, '{8'h82, 8'h03}, '{8'h83, 8'h04},
         '{8'h84, 8'h05}, '{8'h85, 8'h06}, '{8'h86, 8'h07}, '{8'h87, 8'h08},
         '{8'h88, 8'h89},
         '{8'h00, 8'h00}, '{8'h00, 8'h00}, '{8'h00, 8'h00}, '{8'h00, 8'h00},
         '{8'h00, 8'h00}, '{8'h00, 8'h00} },
      '{ '{8'h01, 8'h02}, '{8'h80, 8'h03}, '{8'h04, 8'h05}, '{8'h81, 8'h82},
         '{8'h83, 8'h84}, '{8'h06, 8'h07}, '{8'h85, 8'h86}, '{8'h87, 8'h08},
         '{8'h88, 8'h09}, '{8'h89, 8'h0a}, '{8'h0b, 8'h0c}, '{8'h8a, 8'h8b},
         '{8'h0d, 8'h0e}, '{8'h8c, 8'h8d}, '{8'h8e, 8'h8f} }
   };

   localparam logic [CODE_W-1:0] SIGN_OFFSET [0:TREES-1] =
      '{5'd4, 5'd5, 5'd7, 5'd10, 5'd16};

   typedef struct packed {
      logic bit_value;
      logic first_bit;
      logic last_bit;
   } item_type;

   typedef struct packed {
      logic [BRC_W-1:0]    bit_rate_code;
      logic [SCOUNT_W-1:0] sample_count;
   } cfg_type;

   typedef struct packed {
      logic                   sample_valid;
      logic [CODE_W-1:0]      code_value;
      logic                   sign_bit;
      logic [MAG_W-1:0]       magnitude;
      logic [INDEX_W-1:0]     sample_index;
      logic                   block_done;
      logic                   block_complete;
      logic [BITS_USED_W-1:0] bits_used;
   } rsp_type;

   // clamp the tree select and fold the node number back into the table
   function automatic logic [7:0] tree_entry(input logic [BRC_W-1:0] brc,
                                             input logic [NODE_W-1:0] node,
                                             input logic bit_value);
      logic [BRC_W-1:0]  sel;
      logic [NODE_W-1:0] row;
      sel = (brc > BRC_MAX) ? BRC_MAX : brc;
      row = (node == NODE_WRAP) ? ROOT_NODE : node;
      return CODE_TREE[sel][row][bit_value];
   endfunction

   function automatic logic [CODE_W-1:0] tree_offset(input logic [BRC_W-1:0] brc);
      logic [BRC_W-1:0] sel;
      sel = (brc > BRC_MAX) ? BRC_MAX : brc;
      return SIGN_OFFSET[sel];
   endfunction

endpackage

// ===== hdl/sbhd_if.sv =====
`timescale 1ns / 1ps

interface sbhd_req_if;
   logic valid;
   logic ready;
   logic bit_value;
   logic first_bit;
   logic last_bit;
   modport source (output valid, output bit_value, output first_bit, output last_bit,
                   input ready);
   modport sink (input valid, input bit_value, input first_bit, input last_bit,
                 output ready);
endinterface

interface sbhd_rsp_if;
   logic        valid;
   logic        ready;
   logic        sample_valid;
   logic [4:0]  code_value;
   logic        sign_bit;
   logic [3:0]  magnitude;
   logic [15:0] sample_index;
   logic        block_done;
   logic        block_complete;
   logic [19:0] bits_used;
   modport source (output valid, output sample_valid, output code_value,
                   output sign_bit, output magnitude, output sample_index,
                   output block_done, output block_complete, output bits_used,
                   input ready);
   modport sink (input valid, input sample_valid, input code_value,
                 input sign_bit, input magnitude, input sample_index,
                 input block_done, input block_complete, input bits_used,
                 output ready);
endinterface

interface sbhd_csr_if;
   logic        valid;
   logic        ready;
   logic [3:0]  index;
   logic [15:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/sar_block_huffman_decoder.sv =====
`timescale 1ns / 1ps

// Bit-serial block decoder for a compressed radar sample stream. Each
// request carries one stream bit; every codeword is a sign bit followed by a
// prefix code from one of five fixed trees picked by bit_rate_code (codes
// above four use the tree of code four). A response is given when a codeword
// completes (sample_valid) and on the bit that ends the block (block_done,
// with block_complete and bits_used); the two may share one response. A
// block ends when sample_count samples are decoded or the last_bit request
// arrives; a codeword cut short by last_bit is dropped and the block is
// reported incomplete. Later bits are dropped until a first_bit request.
// Rate: one request per cycle sustained; a request passes the request queue
// and then the response register. The rate is set by the tree step in the
// decode stage, which takes one queued bit each cycle while the response register
// is free or being taken. A two-entry request queue separates intake from
// decode. Configuration writes are always accepted and take effect at once;
// write them only while no request is outstanding.
module sar_block_huffman_decoder #(
   parameter int BIT_COUNT_WIDTH    = sbhd_pkg::BIT_COUNT_WIDTH_DEF,
   parameter int SAMPLE_COUNT_WIDTH = sbhd_pkg::SAMPLE_COUNT_WIDTH_DEF
) (
   input logic         clock,
   input logic         reset,
   sbhd_req_if.sink    req_ch,
   sbhd_rsp_if.source  rsp_ch,
   sbhd_csr_if.sink    csr_ch
);

   sbhd_pkg::item_type in_item;
   sbhd_pkg::item_type q_item;
   sbhd_pkg::rsp_type  rsp;
   sbhd_pkg::cfg_type  cfg;
   logic               q_valid;
   logic               q_pop;

   logic [sbhd_pkg::BRC_W-1:0]    bit_rate_code_ff, bit_rate_code_in;
   logic [sbhd_pkg::SCOUNT_W-1:0] sample_count_ff, sample_count_in;
   logic                          csr_write;

   // configuration registers: writes beyond the list are taken and dropped
   assign csr_ch.ready = 1'b1;
   assign csr_write    = csr_ch.valid && csr_ch.ready;

   always_comb begin
      bit_rate_code_in = bit_rate_code_ff;
      sample_count_in  = sample_count_ff;
      if (csr_write) begin
         case (csr_ch.index)
            sbhd_pkg::CSR_BIT_RATE_CODE: begin
               bit_rate_code_in = csr_ch.data[sbhd_pkg::BRC_W-1:0];
            end
            sbhd_pkg::CSR_SAMPLE_COUNT: begin
               sample_count_in = csr_ch.data[sbhd_pkg::SCOUNT_W-1:0];
            end
            default: begin
               bit_rate_code_in = bit_rate_code_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_rate_code_ff <= '0;
         sample_count_ff  <= sbhd_pkg::SCOUNT_W'(1);
      end else begin
         bit_rate_code_ff <= bit_rate_code_in;
         sample_count_ff  <= sample_count_in;
      end
   end

   assign cfg.bit_rate_code = bit_rate_code_ff;
   assign cfg.sample_count  = sample_count_ff;

   // pack the request payload for the queue
   assign in_item.bit_value = req_ch.bit_value;
   assign in_item.first_bit = req_ch.first_bit;
   assign in_item.last_bit  = req_ch.last_bit;

   sbhd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_ch.valid),
      .in_ready (req_ch.ready),
      .in_item  (in_item),
      .q_valid  (q_valid),
      .q_pop    (q_pop),
      .q_item   (q_item)
   );

   sbhd_back #(
      .BIT_COUNT_WIDTH    (BIT_COUNT_WIDTH),
      .SAMPLE_COUNT_WIDTH (SAMPLE_COUNT_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_item    (q_item),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_rsp   (rsp)
   );

   // unpack the held response onto the channel
   assign rsp_ch.sample_valid   = rsp.sample_valid;
   assign rsp_ch.code_value     = rsp.code_value;
   assign rsp_ch.sign_bit       = rsp.sign_bit;
   assign rsp_ch.magnitude      = rsp.magnitude;
   assign rsp_ch.sample_index   = rsp.sample_index;
   assign rsp_ch.block_done     = rsp.block_done;
   assign rsp_ch.block_complete = rsp.block_complete;
   assign rsp_ch.bits_used      = rsp.bits_used;

   a_brc_write: assert property (@(posedge clock) disable iff (reset)
      csr_write && csr_ch.index == sbhd_pkg::CSR_BIT_RATE_CODE |=>
      bit_rate_code_ff == $past(csr_ch.data[sbhd_pkg::BRC_W-1:0]))
      else $error("bit rate code write lost");

   a_count_write: assert property (@(posedge clock) disable iff (reset)
      csr_write && csr_ch.index == sbhd_pkg::CSR_SAMPLE_COUNT |=>
      sample_count_ff == $past(csr_ch.data))
      else $error("sample count write lost");

   a_stray_write: assert property (@(posedge clock) disable iff (reset)
      csr_write && csr_ch.index != sbhd_pkg::CSR_BIT_RATE_CODE &&
      csr_ch.index != sbhd_pkg::CSR_SAMPLE_COUNT |=>
      $stable(bit_rate_code_ff) && $stable(sample_count_ff))
      else $error("write beyond the register list changed a register");

endmodule

// ===== hdl/sbhd_front.sv =====
`timescale 1ns / 1ps

module sbhd_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  sbhd_pkg::item_type in_item,
   output logic               q_valid,
   input  logic               q_pop,
   output sbhd_pkg::item_type q_item
);

   sbhd_pkg::item_type slot_ff [0:1];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;

   assign in_ready = (count_ff != 2'd2);
   assign push     = in_valid && in_ready;
   assign q_valid  = (count_ff != 2'd0);
   assign q_item   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !q_pop) begin
         count_in = count_ff + 2'd1;
      end else if (q_pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_item;
      end
   end

   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("request queue count out of range");

   a_pop_needs_entry: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> count_ff != 2'd0)
      else $error("pop from empty request queue");

   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      count_ff == 2'd2 && !q_pop |=> count_ff == 2'd2)
      else $error("full request queue lost an entry");

endmodule

// ===== hdl/sbhd_back.sv =====
`timescale 1ns / 1ps

module sbhd_back #(
   parameter int BIT_COUNT_WIDTH    = sbhd_pkg::BIT_COUNT_WIDTH_DEF,
   parameter int SAMPLE_COUNT_WIDTH = sbhd_pkg::SAMPLE_COUNT_WIDTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  sbhd_pkg::cfg_type  cfg,
   input  logic               q_valid,
   output logic               q_pop,
   input  sbhd_pkg::item_type q_item,
   output logic               out_valid,
   input  logic               out_ready,
   output sbhd_pkg::rsp_type  out_rsp
);

   localparam int SW = (SAMPLE_COUNT_WIDTH > sbhd_pkg::SCOUNT_W) ?
                       SAMPLE_COUNT_WIDTH : sbhd_pkg::SCOUNT_W;
   localparam int BW = (BIT_COUNT_WIDTH > sbhd_pkg::BITS_USED_W) ?
                       BIT_COUNT_WIDTH : sbhd_pkg::BITS_USED_W;

   logic [sbhd_pkg::NODE_W-1:0] tree_node_ff, tree_node_in;
   logic                        expect_sign_ff, expect_sign_in;
   logic                        held_sign_ff, held_sign_in;
   logic [SAMPLE_COUNT_WIDTH-1:0] samples_ff, samples_in;
   logic [BIT_COUNT_WIDTH-1:0]    bit_count_ff, bit_count_in;
   logic                        finished_ff, finished_in;
   logic                        out_valid_ff, out_valid_in;
   sbhd_pkg::rsp_type           rsp_ff, rsp_in;

   logic [sbhd_pkg::NODE_W-1:0]   node_cur;
   logic                          expect_cur, held_cur, finished_cur;
   logic [SAMPLE_COUNT_WIDTH-1:0] samples_cur;
   logic [BIT_COUNT_WIDTH-1:0]    bits_cur;
   logic [7:0]                    entry;
   logic                          sample, done, complete, load;
   logic [sbhd_pkg::MAG_W-1:0]    mag;
   logic [SW-1:0]                 samples_wide, index_wide;
   logic [BW-1:0]                 bits_wide;

   assign q_pop     = q_valid && (!out_valid_ff || out_ready);
   assign out_valid = out_valid_ff;
   assign out_rsp   = rsp_ff;

   always_comb begin
      // start of block: decode from a cleared state
      node_cur     = q_item.first_bit ? sbhd_pkg::ROOT_NODE : tree_node_ff;
      expect_cur   = q_item.first_bit ? 1'b1 : expect_sign_ff;
      held_cur     = q_item.first_bit ? 1'b0 : held_sign_ff;
      finished_cur = q_item.first_bit ? 1'b0 : finished_ff;
      samples_cur  = q_item.first_bit ? '0 : samples_ff;
      bits_cur     = q_item.first_bit ? '0 : bit_count_ff;

      entry = sbhd_pkg::tree_entry(cfg.bit_rate_code, node_cur, q_item.bit_value);
      mag   = entry[sbhd_pkg::MAG_W-1:0];

      tree_node_in   = node_cur;
      expect_sign_in = expect_cur;
      held_sign_in   = held_cur;
      samples_in     = samples_cur;
      bit_count_in   = bits_cur;
      finished_in    = finished_cur;
      sample         = 1'b0;
      done           = 1'b0;
      complete       = 1'b0;
      index_wide     = SW'(samples_cur);

      if (!finished_cur) begin
         if (SW'(samples_cur) >= SW'(cfg.sample_count)) begin
            done     = 1'b1;
            complete = 1'b1;
         end else begin
            if (bits_cur != '1) begin
               bit_count_in = bits_cur + 1'b1;
            end
            if (expect_cur) begin
               held_sign_in   = q_item.bit_value;
               expect_sign_in = 1'b0;
               tree_node_in   = sbhd_pkg::ROOT_NODE;
            end else if (entry[7]) begin
               sample         = 1'b1;
               expect_sign_in = 1'b1;
               tree_node_in   = sbhd_pkg::ROOT_NODE;
               if (samples_cur != '1) begin
                  samples_in = samples_cur + 1'b1;
               end
               if (SW'(samples_in) >= SW'(cfg.sample_count)) begin
                  done     = 1'b1;
                  complete = 1'b1;
               end
            end else begin
               tree_node_in = entry[sbhd_pkg::NODE_W-1:0];
            end
            if (q_item.last_bit) begin
               done = 1'b1;
            end
         end
         if (done) begin
            finished_in    = 1'b1;
            expect_sign_in = 1'b1;
            tree_node_in   = sbhd_pkg::ROOT_NODE;
         end
      end

      samples_wide = index_wide;
      bits_wide    = BW'(bit_count_in);
      load         = q_pop && (sample || done);

      rsp_in = '0;
      if (sample) begin
         rsp_in.sample_valid = 1'b1;
         rsp_in.sign_bit     = held_cur;
         rsp_in.magnitude    = mag;
         rsp_in.code_value   = {1'b0, mag} +
            (held_cur ? sbhd_pkg::tree_offset(cfg.bit_rate_code) : '0);
         rsp_in.sample_index = samples_wide[sbhd_pkg::INDEX_W-1:0];
      end
      if (done) begin
         rsp_in.block_done     = 1'b1;
         rsp_in.block_complete = complete;
         rsp_in.bits_used      = bits_wide[sbhd_pkg::BITS_USED_W-1:0];
      end

      if (load) begin
         out_valid_in = 1'b1;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tree_node_ff   <= sbhd_pkg::ROOT_NODE;
         expect_sign_ff <= 1'b1;
         held_sign_ff   <= 1'b0;
         samples_ff     <= '0;
         bit_count_ff   <= '0;
         finished_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         if (q_pop) begin
            tree_node_ff   <= tree_node_in;
            expect_sign_ff <= expect_sign_in;
            held_sign_ff   <= held_sign_in;
            samples_ff     <= samples_in;
            bit_count_ff   <= bit_count_in;
            finished_ff    <= finished_in;
         end
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   a_ended_block_quiet: assert property (@(posedge clock) disable iff (reset)
      q_pop && finished_ff && !q_item.first_bit |-> !load)
      else $error("result from an ended block");

   a_sign_at_root: assert property (@(posedge clock) disable iff (reset)
      expect_sign_ff |-> tree_node_ff == sbhd_pkg::ROOT_NODE)
      else $error("awaiting sign bit away from the root node");

   a_finished_rearmed: assert property (@(posedge clock) disable iff (reset)
      finished_ff |-> expect_sign_ff)
      else $error("ended block not rearmed for a sign bit");

   a_node_in_table: assert property (@(posedge clock) disable iff (reset)
      tree_node_ff != sbhd_pkg::NODE_WRAP)
      else $error("tree node beyond the table");

endmodule

// ===== tb/sbhd_checker.sv =====
`timescale 1ns / 1ps

// Watches the three channels, keeps a private copy of the decoder state and
// the configuration, and compares every response with the oldest prediction.
module sbhd_checker
   import sbhd_pkg::*;
(
   input  logic clock,
   input  logic reset,
   sbhd_req_if  req_mon,
   sbhd_rsp_if  rsp_mon,
   sbhd_csr_if  csr_mon,
   output int   fail_count,
   output int   pending,
   output int   bits_taken,
   output int   samples_seen,
   output int   blocks_seen
);

   // leaf set: val is the magnitude, otherwise val is the next node
   typedef struct packed {
      logic             leaf;
      logic [MAG_W-1:0] val;
   } hop_type;

   logic [BRC_W-1:0]    rate_code;
   logic [SCOUNT_W-1:0] sample_target;

   logic [NODE_W-1:0]                 node_q;
   logic                              sign_due;
   logic                              sign_held;
   logic [SAMPLE_COUNT_WIDTH_DEF-1:0] done_count;
   logic [BIT_COUNT_WIDTH_DEF-1:0]    bit_total;
   logic                              block_over;

   rsp_type expected_q[$];

   function automatic hop_type tree_hop(input logic [BRC_W-1:0] brc,
                                        input logic [NODE_W-1:0] node,
                                        input logic b);
      hop_type h;
      int      sel;
      int      n;
      int      chain_end;
      h = '0;  // node absent from this tree: back to the root
      sel = (brc > 3'd4) ? 4 : int'(brc);
      n = (node == 4'd15) ? 0 : int'(node);
      case (sel)
         0, 1, 2: begin
            chain_end = (sel == 0) ? 2 : (sel == 1) ? 3 : 5;
            if (n < chain_end) begin
               h.leaf = !b;
               h.val  = 4'(b ? n + 1 : n);
            end else if (n == chain_end) begin
               h.leaf = 1'b1;
               h.val  = 4'(n + int'(b));
            end
         end
         3: begin
            if (n == 0) begin
               h.val = b ? 4'd2 : 4'd1;
            end else if (n == 1) begin
               h.leaf = 1'b1;
               h.val  = {3'b000, b};
            end else if (n < 8) begin
               h.leaf = !b;
               h.val  = 4'(b ? n + 1 : n);
            end else if (n == 8) begin
               h.leaf = 1'b1;
               h.val  = 4'(8 + int'(b));
            end
         end
         default: begin
            // 5'h1m is the leaf of magnitude m
            case (n)
               0:  h = b ? 5'h02 : 5'h01;
               1:  h = b ? 5'h03 : 5'h10;
               2:  h = b ? 5'h05 : 5'h04;
               3:  h = b ? 5'h12 : 5'h11;
               4:  h = b ? 5'h14 : 5'h13;
               5:  h = b ? 5'h07 : 5'h06;
               6:  h = b ? 5'h16 : 5'h15;
               7:  h = b ? 5'h08 : 5'h17;
               8:  h = b ? 5'h09 : 5'h18;
               9:  h = b ? 5'h0a : 5'h19;
               10: h = b ? 5'h0c : 5'h0b;
               11: h = b ? 5'h1b : 5'h1a;
               12: h = b ? 5'h0e : 5'h0d;
               13: h = b ? 5'h1d : 5'h1c;
               default: h = b ? 5'h1f : 5'h1e;
            endcase
         end
      endcase
      return h;
   endfunction

   function automatic logic [CODE_W-1:0] offset_for(input logic [BRC_W-1:0] brc);
      case (brc)
         3'd0:    return 5'd4;
         3'd1:    return 5'd5;
         3'd2:    return 5'd7;
         3'd3:    return 5'd10;
         default: return 5'd16;
      endcase
   endfunction

   task automatic clear_block();
      node_q     = ROOT_NODE;
      sign_due   = 1'b1;
      sign_held  = 1'b0;
      done_count = '0;
      bit_total  = '0;
      block_over = 1'b0;
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_type r;
      rsp_type want;
      hop_type h;
      logic    ends;
      logic    full;
      if (reset) begin
         rate_code     = '0;
         sample_target = 16'd1;
         clear_block();
         expected_q.delete();
         fail_count   = 0;
         bits_taken   = 0;
         samples_seen = 0;
         blocks_seen  = 0;
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               CSR_BIT_RATE_CODE: rate_code = csr_mon.data[BRC_W-1:0];
               CSR_SAMPLE_COUNT:  sample_target = csr_mon.data;
               default: ;
            endcase
         end

         if (req_mon.valid && req_mon.ready) begin
            r = '0;
            ends = 1'b0;
            full = 1'b0;
            if (req_mon.first_bit) clear_block();
            if (!block_over) begin
               bits_taken++;
               if (done_count >= sample_target) begin
                  // count already met: bit not consumed
                  ends = 1'b1;
                  full = 1'b1;
               end else begin
                  if (bit_total != '1) bit_total++;
                  if (sign_due) begin
                     sign_held = req_mon.bit_value;
                     sign_due  = 1'b0;
                     node_q    = ROOT_NODE;
                  end else begin
                     h = tree_hop(rate_code, node_q, req_mon.bit_value);
                     if (h.leaf) begin
                        r.sample_valid = 1'b1;
                        r.magnitude    = h.val;
                        r.sign_bit     = sign_held;
                        r.code_value   = {1'b0, h.val} +
                                         (sign_held ? offset_for(rate_code) : 5'd0);
                        r.sample_index = done_count;
                        if (done_count != '1) done_count++;
                        sign_due = 1'b1;
                        node_q   = ROOT_NODE;
                        if (done_count >= sample_target) begin
                           ends = 1'b1;
                           full = 1'b1;
                        end
                     end else begin
                        node_q = h.val;
                     end
                  end
                  if (req_mon.last_bit) ends = 1'b1;
               end
               if (ends) begin
                  block_over       = 1'b1;
                  sign_due         = 1'b1;
                  node_q           = ROOT_NODE;
                  r.block_done     = 1'b1;
                  r.block_complete = full;
                  r.bits_used      = bit_total[BITS_USED_W-1:0];
               end
               if (r.sample_valid || ends) expected_q.push_back(r);
            end
         end

         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_q.size() == 0) begin
               $error("response arrived with no prediction waiting");
               fail_count++;
            end else begin
               want = expected_q.pop_front();
               compare_field("sample_valid", want.sample_valid, rsp_mon.sample_valid);
               compare_field("code_value", want.code_value, rsp_mon.code_value);
               compare_field("sign_bit", want.sign_bit, rsp_mon.sign_bit);
               compare_field("magnitude", want.magnitude, rsp_mon.magnitude);
               compare_field("sample_index", want.sample_index, rsp_mon.sample_index);
               compare_field("block_done", want.block_done, rsp_mon.block_done);
               compare_field("block_complete", want.block_complete,
                             rsp_mon.block_complete);
               compare_field("bits_used", want.bits_used, rsp_mon.bits_used);
               samples_seen += int'(want.sample_valid);
               blocks_seen  += int'(want.block_done);
            end
         end
      end
      pending = expected_q.size();
   end

endmodule

// ===== tb/tb_sar_block_huffman_decoder.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict for the block decoder. The checker beside the block
// does all prediction and comparison; this module only drives requests,
// register writes and response back-pressure, then reads the failure count.
module tb_sar_block_huffman_decoder;
   import sbhd_pkg::*;

   localparam int CLOCK_PERIOD = 12;
   localparam int RESET_CYCLES = 12;
   localparam int RANDOM_BITS  = 420;   // requests sent in the random part
   localparam int PHASE_BITS   = 50;    // requests sent per configuration phase
   localparam int IDLE_PERCENT = 19;
   localparam int DRAIN_CYCLES = 12;    // queue of two plus two stages, with margin
   localparam int DRAIN_LIMIT  = 5000;
   localparam int CYCLE_LIMIT  = 200000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sbhd_req_if req_ch ();
   sbhd_rsp_if rsp_ch ();
   sbhd_csr_if csr_ch ();

   int fail_count;
   int pending;
   int taken_bits;
   int samples_seen;
   int blocks_seen;
   int cycles = 0;
   int phases = 0;
   int sent = 0;       // requests accepted by the block
   bit calm = 1'b0;    // set: no gaps on either side

   sar_block_huffman_decoder u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   sbhd_checker u_check (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_ch),
      .rsp_mon      (rsp_ch),
      .csr_mon      (csr_ch),
      .fail_count   (fail_count),
      .pending      (pending),
      .bits_taken   (taken_bits),
      .samples_seen (samples_seen),
      .blocks_seen  (blocks_seen)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Guard against a hung handshake or a lost response.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $error("cycle limit of %0d reached", CYCLE_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Response back-pressure: stall at random except in the calm stretch.
   always @(negedge clock) begin
      rsp_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
   end

   // Offer one request, with random gaps in front of it; hold valid high
   // across back-to-back requests so it is never lowered and raised at once.
   task automatic send_request(input item_type it);
      while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.bit_value <= it.bit_value;
      req_ch.first_bit <= it.first_bit;
      req_ch.last_bit  <= it.last_bit;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sent++;
      @(negedge clock);
   endtask

   // Send a sign bit and then the low len bits of pat, most significant
   // first; first_bit rides on the sign, last_bit on the final bit sent.
   task automatic send_code(input logic first, input logic sign, input int len,
                            input logic [8:0] pat, input logic last);
      item_type it;
      int       k;
      it.bit_value = sign;
      it.first_bit = first;
      it.last_bit  = last && (len == 0);
      send_request(it);
      for (k = len - 1; k >= 0; k--) begin
         it.bit_value = pat[k];
         it.first_bit = 1'b0;
         it.last_bit  = last && (k == 0);
         send_request(it);
      end
   endtask

   // Bits with random markers: broken blocks, continuations across a
   // register change, and bits after the block has ended.
   task automatic send_noise(input int n);
      item_type it;
      repeat (n) begin
         it.bit_value = 1'($urandom_range(0, 1));
         it.first_bit = ($urandom_range(0, 7) == 0);
         it.last_bit  = ($urandom_range(0, 7) == 0);
         send_request(it);
      end
   endtask

   // Register write; valid drops in a step of its own so that writes in a
   // row never raise and lower it in the same step.
   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
      @(negedge clock);
   endtask

   // Drop valid, wait for every predicted response, then let any bit that
   // causes no response run through the pipeline before touching registers.
   task automatic settle();
      req_ch.valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Codeword for a magnitude in the tree that brc selects, written from the
   // tree shapes directly: len bits in the low end of pat, sent highest first.
   function automatic void encode_sample(input logic [BRC_W-1:0] brc, input int mag,
                                         output int len, output logic [8:0] pat);
      int sel;
      int chain_end;
      int m;
      sel = (brc > 3'd4) ? 4 : int'(brc);
      case (sel)
         0, 1, 2: begin
            // ones walk down the chain, a zero leaves it; the end node's
            // one-branch is the largest magnitude
            chain_end = (sel == 0) ? 2 : (sel == 1) ? 3 : 5;
            m = mag % (chain_end + 2);
            if (m <= chain_end) begin
               len = m + 1;
               pat = 9'(((1 << m) - 1) << 1);
            end else begin
               len = chain_end + 1;
               pat = 9'((1 << len) - 1);
            end
         end
         3: begin
            // a zero first reaches magnitudes 0 and 1; a one enters the chain
            m = mag % 10;
            if (m < 2) begin
               len = 2;
               pat = 9'(m);
            end else if (m < 9) begin
               len = m;
               pat = 9'(((1 << (m - 1)) - 1) << 1);
            end else begin
               len = 8;
               pat = 9'h0ff;
            end
         end
         default: begin
            case (mag % 16)
               0:  begin len = 2; pat = 9'b000000000; end
               1:  begin len = 3; pat = 9'b000000010; end
               2:  begin len = 3; pat = 9'b000000011; end
               3:  begin len = 3; pat = 9'b000000100; end
               4:  begin len = 3; pat = 9'b000000101; end
               5:  begin len = 4; pat = 9'b000001100; end
               6:  begin len = 4; pat = 9'b000001101; end
               7:  begin len = 4; pat = 9'b000001110; end
               8:  begin len = 5; pat = 9'b000011110; end
               9:  begin len = 6; pat = 9'b000111110; end
               10: begin len = 8; pat = 9'b011111100; end
               11: begin len = 8; pat = 9'b011111101; end
               12: begin len = 9; pat = 9'b111111100; end
               13: begin len = 9; pat = 9'b111111101; end
               14: begin len = 9; pat = 9'b111111110; end
               default: begin len = 9; pat = 9'b111111111; end
            endcase
         end
      endcase
   endfunction

   initial begin
      int               random_goal;
      int               phase_goal;
      int               nsamp;
      int               ending;
      int               s;
      int               len;
      int               keep;
      int               drain;
      logic [8:0]       pat;
      logic [BRC_W-1:0] brc;
      logic [15:0]      count;
      item_type         it;

      // every block input known from time zero
      req_ch.valid     = 1'b0;
      req_ch.bit_value = 1'b0;
      req_ch.first_bit = 1'b0;
      req_ch.last_bit  = 1'b0;
      csr_ch.valid     = 1'b0;
      csr_ch.index     = '0;
      csr_ch.data      = '0;
      rsp_ch.ready     = 1'b0;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // ---- directed part ----
      // unmapped index: must leave both registers alone
      write_register(4'hF, 16'(($urandom)));
      write_register(CSR_BIT_RATE_CODE, 16'd0);
      write_register(CSR_SAMPLE_COUNT, 16'd2);
      // negative zero (code 4), then magnitude 3 which also meets the count
      send_code(1'b1, 1'b1, 1, 9'b0, 1'b0);
      send_code(1'b0, 1'b0, 3, 9'b111, 1'b0);

      // all data bits high: tree select seven falls back to the widest tree
      settle();
      write_register(CSR_BIT_RATE_CODE, 16'hFFFF);
      write_register(CSR_SAMPLE_COUNT, 16'hFFFF);
      // longest codeword, largest magnitude with sign: code 31
      send_code(1'b1, 1'b1, 9, 9'h1FF, 1'b0);
      // stop two bits into a codeword, at a node the small tree lacks
      send_code(1'b0, 1'b0, 2, 9'b11, 1'b0);
      settle();
      write_register(CSR_BIT_RATE_CODE, 16'd0);
      // tree changed mid-codeword, and the last bit lands in the middle
      it = '{bit_value: 1'b1, first_bit: 1'b0, last_bit: 1'b1};
      send_request(it);

      // lone sign bit carrying last_bit
      settle();
      write_register(CSR_BIT_RATE_CODE, 16'd2);
      send_code(1'b1, 1'b0, 0, 9'b0, 1'b1);

      // count lowered to what is already decoded: next bit ends complete
      settle();
      write_register(CSR_BIT_RATE_CODE, 16'd1);
      write_register(CSR_SAMPLE_COUNT, 16'd5);
      send_code(1'b1, 1'b0, 1, 9'b0, 1'b0);
      settle();
      write_register(CSR_SAMPLE_COUNT, 16'd1);
      it = '{bit_value: 1'b1, first_bit: 1'b0, last_bit: 1'b0};
      send_request(it);

      // ---- random part ----
      // Each phase picks a tree and a count, then sends mostly well-formed
      // blocks with random signs and magnitudes, plus some noise.
      settle();
      random_goal = sent + RANDOM_BITS;
      while (sent < random_goal) begin
         settle();
         brc = (phases < 8) ? 3'(phases) : 3'($urandom_range(0, 7));
         case (phases % 8)
            0: count = 16'd4;
            1: count = 16'd1;
            2: count = 16'hFFFF;
            3: count = 16'd2;
            4: count = 16'd0;
            5: count = 16'd7;
            6: count = 16'd3;
            default: count = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                         : 16'($urandom_range(1, 12));
         endcase
         // a long stretch without gaps on either side
         calm = (phases >= 3 && phases <= 5);
         // stray upper bits in the tree select must be masked off
         write_register(CSR_BIT_RATE_CODE, (16'($urandom) & 16'hFFF8) | 16'(brc));
         write_register(CSR_SAMPLE_COUNT, count);
         if ($urandom_range(0, 3) == 0)
            write_register(4'($urandom_range(2, 15)), 16'($urandom));
         phase_goal = sent + ((count == 16'd0) ? PHASE_BITS / 3 : PHASE_BITS);
         // leftover bits from the previous phase meet the new settings
         send_noise($urandom_range(0, 3));
         while (sent < phase_goal) begin
            if ($urandom_range(0, 99) < 85) begin
               nsamp  = $urandom_range(1, 6);
               ending = $urandom_range(0, 2);  // last on a codeword, cut short, none
               for (s = 0; s < nsamp; s++) begin
                  encode_sample(brc, $urandom_range(0, 15), len, pat);
                  send_code(s == 0, 1'($urandom_range(0, 1)), len, pat,
                            (ending == 0) && (s == nsamp - 1));
               end
               if (ending == 1) begin
                  encode_sample(brc, $urandom_range(0, 15), len, pat);
                  keep = $urandom_range(0, len - 1);
                  send_code(1'b0, 1'($urandom_range(0, 1)), keep, pat >> (len - keep),
                            1'b1);
               end
            end else begin
               send_noise($urandom_range(1, 4));
            end
         end
         phases++;
      end
      calm = 1'b0;

      // ---- drain and verdict ----
      req_ch.valid <= 1'b0;
      drain = 0;
      while (pending != 0 && drain < DRAIN_LIMIT) begin
         @(negedge clock);
         drain++;
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (pending != 0) $error("%0d predicted responses never arrived", pending);

      $display("Run covered %0d requests (%0d decoded bits) in %0d random phases",
               sent, taken_bits, phases);
      $display("over all tree selects, with %0d samples and %0d block ends checked.",
               samples_seen, blocks_seen);
      if (fail_count == 0 && pending == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
